### design/pgs_hdr_pkg.sv
`default_nettype none

package pgs_hdr_pkg;

    localparam int unsigned HDR_LEN = 13;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_MAGIC = 3'd2;
    localparam logic [2:0] ST_TYPE  = 3'd3;
    localparam logic [2:0] ST_SIZE  = 3'd4;

    // segment kinds
    localparam logic [2:0] KIND_PALETTE     = 3'd0;
    localparam logic [2:0] KIND_OBJECT      = 3'd1;
    localparam logic [2:0] KIND_COMPOSITION = 3'd2;
    localparam logic [2:0] KIND_WINDOW      = 3'd3;
    localparam logic [2:0] KIND_END         = 3'd4;

    // segment type bytes
    localparam logic [7:0] TYPE_PALETTE     = 8'h14;
    localparam logic [7:0] TYPE_OBJECT      = 8'h15;
    localparam logic [7:0] TYPE_COMPOSITION = 8'h16;
    localparam logic [7:0] TYPE_WINDOW      = 8'h17;
    localparam logic [7:0] TYPE_END         = 8'h80;

    localparam logic [7:0] MAGIC_HIGH = 8'h50;
    localparam logic [7:0] MAGIC_LOW  = 8'h47;

    // 90 kHz ticks to ms: (t + 45) / 90 = ((t + 45) >> 1) / 45
    localparam logic [5:0]  MS_HALF_DIV = 6'd45;
    localparam logic [32:0] MS_ROUND    = 33'd45;
    // floor(2^32 / 45)
    localparam logic [26:0] MS_RECIP    = 27'd95443717;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] ticks_t;
    typedef logic [25:0] ms_t;

    function automatic logic type_known(input byte_t t);
        return (t == TYPE_PALETTE) || (t == TYPE_OBJECT) || (t == TYPE_COMPOSITION)
            || (t == TYPE_WINDOW) || (t == TYPE_END);
    endfunction

    function automatic logic [2:0] type_kind(input byte_t t);
        logic [2:0] k;
        k = KIND_PALETTE;
        case (t)
            TYPE_PALETTE:     k = KIND_PALETTE;
            TYPE_OBJECT:      k = KIND_OBJECT;
            TYPE_COMPOSITION: k = KIND_COMPOSITION;
            TYPE_WINDOW:      k = KIND_WINDOW;
            TYPE_END:         k = KIND_END;
            default:          k = KIND_PALETTE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### design/pgs_segment_header_parser.sv
// Segment header parser for presentation-graphics streams.
// Input channel (s_valid/s_ready): one header byte per request in s_data_byte,
// with s_bytes_remaining giving the buffer bytes from that byte onward.
// Result channel (m_valid/m_ready): one request per complete 13-byte header
// (status ok or size overrun, with the decoded fields), or one status request
// at the first error (short header, bad magic, unknown type), after which the
// next byte is taken as a new header start.
// Throughput: one byte per cycle while results are taken. A byte is
// accepted whenever the result register is empty or being drained.
// Latency: the result appears in m_* the cycle after the byte that ends
// the header or raises the error is accepted.
// Timestamp to millisecond conversion runs in a two-stage reciprocal
// multiplier behind each timestamp register; it settles before the last
// header byte is taken, which the header layout always leaves room for.
// Reset clears the byte position and the result valid; the next byte after
// reset is a header start. When the receiver stalls, the pending result holds
// and s_ready stays low until it is taken.
`default_nettype none

module pgs_segment_header_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [31:0] s_bytes_remaining,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_pts_stamp,
    output logic [25:0]      m_pts_ms,
    output logic [31:0]      m_dts_stamp,
    output logic [25:0]      m_dts_ms,
    output logic [2:0]       m_segment_kind,
    output logic [7:0]       m_type_byte,
    output logic [15:0]      m_payload_size
);

    localparam logic [3:0] POS_MAGIC_HI = 4'd0;
    localparam logic [3:0] POS_MAGIC_LO = 4'd1;
    localparam logic [3:0] POS_PTS_FIRST = 4'd2;
    localparam logic [3:0] POS_PTS_LAST = 4'd5;
    localparam logic [3:0] POS_DTS_FIRST = 4'd6;
    localparam logic [3:0] POS_DTS_LAST = 4'd9;
    localparam logic [3:0] POS_TYPE = 4'd10;
    localparam logic [3:0] POS_SIZE_HI = 4'd11;
    localparam logic [3:0] POS_SIZE_LO = 4'd12;

    logic [3:0]           pos_reg, pos_next, pos;
    pgs_hdr_pkg::byte_t   magic_high_reg, magic_high_next;
    pgs_hdr_pkg::ticks_t  pts_shift_reg, pts_shift_next;
    pgs_hdr_pkg::ticks_t  dts_shift_reg, dts_shift_next;
    pgs_hdr_pkg::byte_t   type_hold_reg, type_hold_next;
    pgs_hdr_pkg::byte_t   size_high_reg, size_high_next;

    // millisecond conversion pipelines
    logic [31:0]          pts_half, dts_half;
    logic [58:0]          pts_prod, dts_prod;
    logic [31:0]          pts_u_reg, dts_u_reg;
    pgs_hdr_pkg::ms_t     pts_q_reg, dts_q_reg;
    logic [31:0]          pts_rem, dts_rem;
    pgs_hdr_pkg::ms_t     pts_ms_reg, pts_ms_next;
    pgs_hdr_pkg::ms_t     dts_ms_reg, dts_ms_next;

    logic                 in_fire;
    logic                 emit;
    logic [15:0]          size_word;
    logic [31:0]          left;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           status_reg, status_next;
    logic [31:0]          pts_stamp_reg, pts_stamp_next;
    logic [25:0]          pts_ms_out_reg, pts_ms_out_next;
    logic [31:0]          dts_stamp_reg, dts_stamp_next;
    logic [25:0]          dts_ms_out_reg, dts_ms_out_next;
    logic [2:0]           kind_reg, kind_next;
    logic [7:0]           type_byte_reg, type_byte_next;
    logic [15:0]          payload_size_reg, payload_size_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // stage 1: (t + 45) >> 1 times the reciprocal of 45
    assign pts_half = 32'(({1'b0, pts_shift_reg} + pgs_hdr_pkg::MS_ROUND) >> 1);
    assign dts_half = 32'(({1'b0, dts_shift_reg} + pgs_hdr_pkg::MS_ROUND) >> 1);
    assign pts_prod = 59'(pts_half) * 59'(pgs_hdr_pkg::MS_RECIP);
    assign dts_prod = 59'(dts_half) * 59'(pgs_hdr_pkg::MS_RECIP);

    // stage 2: estimate is low by at most one, fix it from the remainder
    assign pts_rem = pts_u_reg - ({6'd0, pts_q_reg} * 32'(pgs_hdr_pkg::MS_HALF_DIV));
    assign dts_rem = dts_u_reg - ({6'd0, dts_q_reg} * 32'(pgs_hdr_pkg::MS_HALF_DIV));
    assign pts_ms_next = pts_q_reg
        + 26'(pts_rem >= 32'(pgs_hdr_pkg::MS_HALF_DIV));
    assign dts_ms_next = dts_q_reg
        + 26'(dts_rem >= 32'(pgs_hdr_pkg::MS_HALF_DIV));

    always_ff @(posedge aclk) begin
        pts_u_reg  <= pts_half;
        dts_u_reg  <= dts_half;
        pts_q_reg  <= pts_prod[57:32];
        dts_q_reg  <= dts_prod[57:32];
        pts_ms_reg <= pts_ms_next;
        dts_ms_reg <= dts_ms_next;
    end

    assign pos = (pos_reg > POS_SIZE_LO) ? POS_MAGIC_HI : pos_reg;
    assign size_word = {size_high_reg, s_data_byte};
    assign left = (s_bytes_remaining == 32'd0) ? 32'd0 : s_bytes_remaining - 32'd1;

    always_comb begin
        pos_next          = pos_reg;
        magic_high_next   = magic_high_reg;
        pts_shift_next    = pts_shift_reg;
        dts_shift_next    = dts_shift_reg;
        type_hold_next    = type_hold_reg;
        size_high_next    = size_high_reg;
        emit              = 1'b0;
        status_next       = pgs_hdr_pkg::ST_OK;
        pts_stamp_next    = 32'd0;
        pts_ms_out_next   = 26'd0;
        dts_stamp_next    = 32'd0;
        dts_ms_out_next   = 26'd0;
        kind_next         = pgs_hdr_pkg::KIND_PALETTE;
        type_byte_next    = 8'd0;
        payload_size_next = 16'd0;

        if (in_fire) begin
            unique case (pos) inside
                POS_MAGIC_HI: begin
                    if (s_bytes_remaining < 32'(pgs_hdr_pkg::HDR_LEN)) begin
                        emit        = 1'b1;
                        status_next = pgs_hdr_pkg::ST_SHORT;
                        pos_next    = POS_MAGIC_HI;
                    end else begin
                        magic_high_next = s_data_byte;
                        pts_shift_next  = 32'd0;
                        dts_shift_next  = 32'd0;
                        pos_next        = POS_MAGIC_LO;
                    end
                end
                POS_MAGIC_LO: begin
                    if (magic_high_reg != pgs_hdr_pkg::MAGIC_HIGH
                            || s_data_byte != pgs_hdr_pkg::MAGIC_LOW) begin
                        emit        = 1'b1;
                        status_next = pgs_hdr_pkg::ST_MAGIC;
                        pos_next    = POS_MAGIC_HI;
                    end else begin
                        pos_next = POS_PTS_FIRST;
                    end
                end
                [POS_PTS_FIRST:POS_PTS_LAST]: begin
                    pts_shift_next = {pts_shift_reg[23:0], s_data_byte};
                    pos_next       = pos + 4'd1;
                end
                [POS_DTS_FIRST:POS_DTS_LAST]: begin
                    dts_shift_next = {dts_shift_reg[23:0], s_data_byte};
                    pos_next       = pos + 4'd1;
                end
                POS_TYPE: begin
                    if (!pgs_hdr_pkg::type_known(s_data_byte)) begin
                        emit           = 1'b1;
                        status_next    = pgs_hdr_pkg::ST_TYPE;
                        type_byte_next = s_data_byte;
                        pos_next       = POS_MAGIC_HI;
                    end else begin
                        type_hold_next = s_data_byte;
                        pos_next       = POS_SIZE_HI;
                    end
                end
                POS_SIZE_HI: begin
                    size_high_next = s_data_byte;
                    pos_next       = POS_SIZE_LO;
                end
                default: begin
                    // last header byte
                    emit              = 1'b1;
                    status_next       = ({16'd0, size_word} > left) ?
                                        pgs_hdr_pkg::ST_SIZE : pgs_hdr_pkg::ST_OK;
                    pts_stamp_next    = pts_shift_reg;
                    pts_ms_out_next   = pts_ms_reg;
                    dts_stamp_next    = dts_shift_reg;
                    dts_ms_out_next   = dts_ms_reg;
                    kind_next         = pgs_hdr_pkg::type_kind(type_hold_reg);
                    type_byte_next    = type_hold_reg;
                    payload_size_next = size_word;
                    pos_next          = POS_MAGIC_HI;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_MAGIC_HI;
            magic_high_reg <= 8'd0;
            pts_shift_reg  <= 32'd0;
            dts_shift_reg  <= 32'd0;
            type_hold_reg  <= 8'd0;
            size_high_reg  <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            magic_high_reg <= magic_high_next;
            pts_shift_reg  <= pts_shift_next;
            dts_shift_reg  <= dts_shift_next;
            type_hold_reg  <= type_hold_next;
            size_high_reg  <= size_high_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && emit) begin
            status_reg       <= status_next;
            pts_stamp_reg    <= pts_stamp_next;
            pts_ms_out_reg   <= pts_ms_out_next;
            dts_stamp_reg    <= dts_stamp_next;
            dts_ms_out_reg   <= dts_ms_out_next;
            kind_reg         <= kind_next;
            type_byte_reg    <= type_byte_next;
            payload_size_reg <= payload_size_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_pts_stamp    = pts_stamp_reg;
    assign m_pts_ms       = pts_ms_out_reg;
    assign m_dts_stamp    = dts_stamp_reg;
    assign m_dts_ms       = dts_ms_out_reg;
    assign m_segment_kind = kind_reg;
    assign m_type_byte    = type_byte_reg;
    assign m_payload_size = payload_size_reg;

endmodule

`default_nettype wire

### design/pgs_hdr_checker.sv
`default_nettype none

module pgs_hdr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_pts_stamp,
    input wire logic [25:0] m_pts_ms,
    input wire logic [31:0] m_dts_stamp,
    input wire logic [25:0] m_dts_ms,
    input wire logic [2:0]  m_segment_kind,
    input wire logic [15:0] m_payload_size
);

    // result slot full and stalled: no byte may be taken
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("byte accepted while result stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_pts_ms)
            && $stable(m_dts_ms) && $stable(m_payload_size))
        else $error("stalled result changed");

    // error results carry no decoded header
    a_error_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pgs_hdr_pkg::ST_SHORT || m_status == pgs_hdr_pkg::ST_MAGIC
            || m_status == pgs_hdr_pkg::ST_TYPE)
        |-> m_pts_stamp == 32'd0 && m_dts_stamp == 32'd0 && m_pts_ms == 26'd0
            && m_dts_ms == 26'd0 && m_payload_size == 16'd0
            && m_segment_kind == pgs_hdr_pkg::KIND_PALETTE)
        else $error("error result carries header fields");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= pgs_hdr_pkg::ST_SIZE
            && m_segment_kind <= pgs_hdr_pkg::KIND_END)
        else $error("status or kind out of range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pgs_segment_header_parser pgs_hdr_checker u_pgs_hdr_checker (.*);

`default_nettype wire

### sim/tb_pgs_segment_header_parser.sv
`default_nettype none

module tb_pgs_segment_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 2000;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    typedef pgs_hdr_pkg::byte_t header_bytes_t [pgs_hdr_pkg::HDR_LEN];

    typedef struct {
        logic [2:0]          status;
        pgs_hdr_pkg::ticks_t pts_stamp;
        pgs_hdr_pkg::ms_t    pts_ms;
        pgs_hdr_pkg::ticks_t dts_stamp;
        pgs_hdr_pkg::ms_t    dts_ms;
        logic [2:0]          segment_kind;
        pgs_hdr_pkg::byte_t  type_byte;
        logic [15:0]         payload_size;
    } header_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic [31:0] s_bytes_remaining;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_pts_stamp;
    logic [25:0] m_pts_ms;
    logic [31:0] m_dts_stamp;
    logic [25:0] m_dts_ms;
    logic [2:0]  m_segment_kind;
    logic [7:0]  m_type_byte;
    logic [15:0] m_payload_size;

    // parser state as seen by the predictor
    logic [3:0]          hdr_pos;
    pgs_hdr_pkg::byte_t  magic_seen;
    pgs_hdr_pkg::ticks_t pts_acc;
    pgs_hdr_pkg::ticks_t dts_acc;
    pgs_hdr_pkg::byte_t  type_seen;
    pgs_hdr_pkg::byte_t  size_msb;

    header_result_t parsed_headers[$];
    header_result_t want_hdr;
    int          mismatch_count;
    int          bytes_sent;
    int          results_seen;
    logic        idle_on;

    pgs_segment_header_parser dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_bytes_remaining (s_bytes_remaining),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_pts_stamp       (m_pts_stamp),
        .m_pts_ms          (m_pts_ms),
        .m_dts_stamp       (m_dts_stamp),
        .m_dts_ms          (m_dts_ms),
        .m_segment_kind    (m_segment_kind),
        .m_type_byte       (m_type_byte),
        .m_payload_size    (m_payload_size)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic pgs_hdr_pkg::ms_t ticks_to_millis(input pgs_hdr_pkg::ticks_t t);
        logic [32:0] sum;
        sum = {1'b0, t} + 33'd45;
        return pgs_hdr_pkg::ms_t'(sum / 33'd90);
    endfunction

    function automatic logic segment_kind_of(input pgs_hdr_pkg::byte_t t,
                                             output logic [2:0] kind);
        kind = pgs_hdr_pkg::KIND_PALETTE;
        case (t)
            pgs_hdr_pkg::TYPE_PALETTE:     kind = pgs_hdr_pkg::KIND_PALETTE;
            pgs_hdr_pkg::TYPE_OBJECT:      kind = pgs_hdr_pkg::KIND_OBJECT;
            pgs_hdr_pkg::TYPE_COMPOSITION: kind = pgs_hdr_pkg::KIND_COMPOSITION;
            pgs_hdr_pkg::TYPE_WINDOW:      kind = pgs_hdr_pkg::KIND_WINDOW;
            pgs_hdr_pkg::TYPE_END:         kind = pgs_hdr_pkg::KIND_END;
            default:                       return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void parse_header_byte(input pgs_hdr_pkg::byte_t b,
                                              input logic [31:0] rem);
        header_result_t r;
        logic [2:0]     kind;
        logic [15:0]    size;
        logic [31:0]    left;
        logic           emit;
        r = '{default: '0};
        emit = 1'b0;
        if (hdr_pos > 4'd12) hdr_pos = 4'd0;
        if (hdr_pos == 4'd0) begin
            if (rem < pgs_hdr_pkg::HDR_LEN) begin
                r.status = pgs_hdr_pkg::ST_SHORT;
                emit = 1'b1;
            end else begin
                magic_seen = b;
                pts_acc = '0;
                dts_acc = '0;
                hdr_pos = 4'd1;
            end
        end else if (hdr_pos == 4'd1) begin
            if (magic_seen != pgs_hdr_pkg::MAGIC_HIGH || b != pgs_hdr_pkg::MAGIC_LOW) begin
                r.status = pgs_hdr_pkg::ST_MAGIC;
                emit = 1'b1;
            end else begin
                hdr_pos = 4'd2;
            end
        end else if (hdr_pos <= 4'd5) begin
            pts_acc = {pts_acc[23:0], b};
            hdr_pos = hdr_pos + 4'd1;
        end else if (hdr_pos <= 4'd9) begin
            dts_acc = {dts_acc[23:0], b};
            hdr_pos = hdr_pos + 4'd1;
        end else if (hdr_pos == 4'd10) begin
            if (!segment_kind_of(b, kind)) begin
                r.status = pgs_hdr_pkg::ST_TYPE;
                r.type_byte = b;
                emit = 1'b1;
            end else begin
                type_seen = b;
                hdr_pos = 4'd11;
            end
        end else if (hdr_pos == 4'd11) begin
            size_msb = b;
            hdr_pos = 4'd12;
        end else begin
            size = {size_msb, b};
            left = (rem == 32'd0) ? 32'd0 : rem - 32'd1;
            void'(segment_kind_of(type_seen, kind));
            r.status       = (size > left) ? pgs_hdr_pkg::ST_SIZE : pgs_hdr_pkg::ST_OK;
            r.pts_stamp    = pts_acc;
            r.pts_ms       = ticks_to_millis(pts_acc);
            r.dts_stamp    = dts_acc;
            r.dts_ms       = ticks_to_millis(dts_acc);
            r.segment_kind = kind;
            r.type_byte    = type_seen;
            r.payload_size = size;
            emit = 1'b1;
        end
        if (emit) begin
            parsed_headers.push_back(r);
            hdr_pos = 4'd0;
        end
    endfunction

    // called and left at a falling edge
    task automatic send_byte(input pgs_hdr_pkg::byte_t data, input logic [31:0] rem);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_data_byte       <= data;
        s_bytes_remaining <= rem;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_header_byte(data, rem);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // middle bytes carry random counts, which the parser ignores
    task automatic send_header(input header_bytes_t hdr, input int count,
                               input logic [31:0] rem_first, input logic [31:0] rem_last);
        logic [31:0] rem;
        for (int i = 0; i < count; i++) begin
            if (i == 0) rem = rem_first;
            else if (i == pgs_hdr_pkg::HDR_LEN - 1) rem = rem_last;
            else rem = $urandom;
            send_byte(hdr[i], rem);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (parsed_headers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
    endtask

    function automatic header_bytes_t pack_header(input pgs_hdr_pkg::ticks_t pts,
                                                  input pgs_hdr_pkg::ticks_t dts,
                                                  input pgs_hdr_pkg::byte_t seg_type,
                                                  input logic [15:0] size);
        header_bytes_t h;
        h[0]  = pgs_hdr_pkg::MAGIC_HIGH;
        h[1]  = pgs_hdr_pkg::MAGIC_LOW;
        h[2]  = pts[31:24];
        h[3]  = pts[23:16];
        h[4]  = pts[15:8];
        h[5]  = pts[7:0];
        h[6]  = dts[31:24];
        h[7]  = dts[23:16];
        h[8]  = dts[15:8];
        h[9]  = dts[7:0];
        h[10] = seg_type;
        h[11] = size[15:8];
        h[12] = size[7:0];
        return h;
    endfunction

    function automatic pgs_hdr_pkg::ticks_t random_ticks();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 200);
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 200);
            // straddle the rounding point
            4:       return 90 * $urandom_range(0, 47721857) + 44 + $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_size();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic pgs_hdr_pkg::byte_t random_known_type();
        case ($urandom_range(0, 4))
            0:       return pgs_hdr_pkg::TYPE_PALETTE;
            1:       return pgs_hdr_pkg::TYPE_OBJECT;
            2:       return pgs_hdr_pkg::TYPE_COMPOSITION;
            3:       return pgs_hdr_pkg::TYPE_WINDOW;
            default: return pgs_hdr_pkg::TYPE_END;
        endcase
    endfunction

    function automatic logic [31:0] random_first_rem();
        case ($urandom_range(0, 4))
            0:       return pgs_hdr_pkg::HDR_LEN;
            1:       return '1;
            2:       return $urandom_range(pgs_hdr_pkg::HDR_LEN, 5000);
            default: return $urandom;
        endcase
    endfunction

    // payload sizes around the exact fit, plus the extremes
    function automatic logic [31:0] random_last_rem(input logic [15:0] size);
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return {16'd0, size} + 32'd1;
            2:       return {16'd0, size};
            3:       return '1;
            4:       return $urandom_range(0, 70000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_short_header();
        send_byte(pgs_hdr_pkg::MAGIC_HIGH, pgs_hdr_pkg::HDR_LEN - 1);
        send_byte(8'hFF, 32'd0);
        drain_results();
    endtask

    task automatic test_bad_magic();
        send_byte(pgs_hdr_pkg::MAGIC_HIGH, pgs_hdr_pkg::HDR_LEN);
        send_byte(8'h00, 32'd0);
        drain_results();
    endtask

    task automatic test_unknown_type();
        send_header(pack_header(32'h1234_5678, 32'h9ABC_DEF0, 8'hFF, 16'h0102), 11,
                    32'hFFFF_FFFF, 32'd0);
        drain_results();
    endtask

    task automatic test_size_extremes();
        // largest timestamp, largest payload, nothing left after the header
        send_header(pack_header(32'hFFFF_FFFF, 32'h0000_0000, pgs_hdr_pkg::TYPE_END,
                                16'hFFFF),
                    pgs_hdr_pkg::HDR_LEN, pgs_hdr_pkg::HDR_LEN, 32'd0);
        drain_results();
    endtask

    task automatic test_random_headers();
        header_bytes_t hdr;
        logic [15:0]   size;
        int            pick;
        int            start_count;
        int            headers_done;
        start_count = bytes_sent;
        headers_done = 0;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            if (headers_done % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 29) == 0) drain_results();
            size = random_size();
            hdr  = pack_header(random_ticks(), random_ticks(), random_known_type(), size);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_byte(pgs_hdr_pkg::byte_t'($urandom),
                          $urandom_range(0, pgs_hdr_pkg::HDR_LEN - 1));
            end else if (pick < 12) begin
                hdr[0] = $urandom_range(0, 1) ? pgs_hdr_pkg::MAGIC_HIGH
                                              : pgs_hdr_pkg::byte_t'($urandom);
                hdr[1] = pgs_hdr_pkg::byte_t'($urandom);
                send_header(hdr, 2, random_first_rem(), 32'd0);
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 5)) send_byte(pgs_hdr_pkg::byte_t'($urandom), $urandom);
            end else if (pick < 26) begin
                hdr[10] = pgs_hdr_pkg::byte_t'($urandom);
                send_header(hdr, 11, random_first_rem(), 32'd0);
            end else begin
                send_header(hdr, pgs_hdr_pkg::HDR_LEN, random_first_rem(),
                            random_last_rem(size));
            end
            headers_done++;
        end
        idle_on = 1'b1;
        drain_results();
    endtask

    // result receiver with random stalls
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (parsed_headers.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d", m_status));
            end else begin
                want_hdr = parsed_headers.pop_front();
                if (m_status !== want_hdr.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want_hdr.status));
                if (m_pts_stamp !== want_hdr.pts_stamp)
                    report_mismatch($sformatf("pts_stamp %h, want %h",
                                              m_pts_stamp, want_hdr.pts_stamp));
                if (m_pts_ms !== want_hdr.pts_ms)
                    report_mismatch($sformatf("pts_ms %0d, want %0d", m_pts_ms, want_hdr.pts_ms));
                if (m_dts_stamp !== want_hdr.dts_stamp)
                    report_mismatch($sformatf("dts_stamp %h, want %h",
                                              m_dts_stamp, want_hdr.dts_stamp));
                if (m_dts_ms !== want_hdr.dts_ms)
                    report_mismatch($sformatf("dts_ms %0d, want %0d", m_dts_ms, want_hdr.dts_ms));
                if (m_segment_kind !== want_hdr.segment_kind)
                    report_mismatch($sformatf("segment_kind %0d, want %0d",
                                              m_segment_kind, want_hdr.segment_kind));
                if (m_type_byte !== want_hdr.type_byte)
                    report_mismatch($sformatf("type_byte %h, want %h",
                                              m_type_byte, want_hdr.type_byte));
                if (m_payload_size !== want_hdr.payload_size)
                    report_mismatch($sformatf("payload_size %h, want %h",
                                              m_payload_size, want_hdr.payload_size));
            end
        end
    end

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_data_byte       = '0;
        s_bytes_remaining = '0;
        idle_on           = 1'b1;
        hdr_pos           = '0;
        magic_seen        = '0;
        pts_acc           = '0;
        dts_acc           = '0;
        type_seen         = '0;
        size_msb          = '0;
        mismatch_count    = 0;
        bytes_sent        = 0;
        results_seen      = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_short_header();
        test_bad_magic();
        test_unknown_type();
        test_size_extremes();
        test_random_headers();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (parsed_headers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", parsed_headers.size()));
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", parsed_headers.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### pgs_segment_header_parser.f
design/pgs_hdr_pkg.sv
design/pgs_segment_header_parser.sv
design/pgs_hdr_checker.sv
sim/tb_pgs_segment_header_parser.sv
